// ----- rtl/core/mtcd_pkg.sv -----
// Shared types and constants for the recency-ordered tag directory.
`default_nettype none
package mtcd_pkg;

  localparam int KEY_W   = 32;
  localparam int FIELD_W = 4;

  typedef struct packed {
    logic signed [KEY_W-1:0] x;
    logic signed [KEY_W-1:0] z;
    logic                    valid;
  } entry_tag_t;

  typedef struct packed {
    logic compare;
    logic update;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/mru_tag_cache_directory_unit.sv -----
// Fully associative tag directory held as a chain of recency cells, front most recent.
// A lookup is taken when start is high and busy is low; the accepting edge registers the
// comparison of every cell against the key, and the update state then shifts the chain
// once and registers done and the result. Busy is high for the update cycle, so a new
// lookup is not taken until the chain has moved.
// Reset leaves recency order as slot i at position i with every slot empty.
`default_nettype none
module mru_tag_cache_directory_unit #(
  parameter int CACHE_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [mtcd_pkg::KEY_W-1:0] key_x,
  input  logic signed [mtcd_pkg::KEY_W-1:0] key_z,
  output logic                              done,
  output logic                              hit,
  output logic [mtcd_pkg::FIELD_W-1:0]      slot,
  output logic [mtcd_pkg::FIELD_W-1:0]      recency_position
);
  import mtcd_pkg::*;

  localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(CACHE_SLOTS - 1);

  state_t state;
  state_t state_next;

  logic                    accept;
  cell_ctrl_t              ctrl;
  logic signed [KEY_W-1:0] key_x_q;
  logic signed [KEY_W-1:0] key_z_q;

  logic [SLOT_W-1:0] cell_slot [CACHE_SLOTS];
  entry_tag_t        cell_tag  [CACHE_SLOTS];
  logic              match     [CACHE_SLOTS];
  logic [SLOT_W-1:0] prev_slot [CACHE_SLOTS];
  entry_tag_t        prev_tag  [CACHE_SLOTS];

  logic              any_hit;
  logic [SLOT_W-1:0] hit_pos;
  logic [SLOT_W-1:0] hit_slot;
  entry_tag_t        hit_tag;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] head_slot;
  entry_tag_t        head_tag;

  logic [SLOT_W+FIELD_W-1:0] slot_ext;
  logic [SLOT_W+FIELD_W-1:0] pos_ext;

  assign accept       = start && !busy;
  assign ctrl.compare = accept;
  assign ctrl.update  = (state == ST_UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE:   state_next = accept ? ST_UPDATE : ST_IDLE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE:   busy = 1'b0;
      ST_UPDATE: busy = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_x_q <= key_x;
      key_z_q <= key_z;
    end
  end

  // Valid tags are unique, so at most one cell matches and plain OR-ing selects it.
  always_comb begin
    any_hit  = 1'b0;
    hit_pos  = '0;
    hit_slot = '0;
    hit_tag  = '0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (match[i]) begin
        any_hit  = 1'b1;
        hit_pos  = hit_pos | SLOT_W'(i);
        hit_slot = hit_slot | cell_slot[i];
        hit_tag  = hit_tag | cell_tag[i];
      end
    end
  end

  // On a miss the back of the chain comes to the front carrying the new key.
  always_comb begin
    if (any_hit) begin
      pos       = hit_pos;
      head_slot = hit_slot;
      head_tag  = hit_tag;
    end else begin
      pos       = LAST;
      head_slot = cell_slot[CACHE_SLOTS-1];
      head_tag  = '{x: key_x_q, z: key_z_q, valid: 1'b1};
    end
  end

  for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_slot[g] = head_slot;
      assign prev_tag[g]  = head_tag;
    end else begin : g_link
      assign prev_slot[g] = cell_slot[g-1];
      assign prev_tag[g]  = cell_tag[g-1];
    end

    mtcd_cell #(
      .SLOT_W (SLOT_W),
      .INDEX  (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .key_x     (key_x),
      .key_z     (key_z),
      .pos       (pos),
      .prev_slot (prev_slot[g]),
      .prev_tag  (prev_tag[g]),
      .cell_slot (cell_slot[g]),
      .cell_tag  (cell_tag[g]),
      .match     (match[g])
    );
  end

  assign slot_ext = {{FIELD_W{1'b0}}, head_slot};
  assign pos_ext  = {{FIELD_W{1'b0}}, hit_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.update;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      hit              <= any_hit;
      slot             <= slot_ext[FIELD_W-1:0];
      recency_position <= any_hit ? pos_ext[FIELD_W-1:0] : '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mtcd_cell.sv -----
// One recency position of the directory: slot number, key tags, valid bit and tag comparator.
`default_nettype none
module mtcd_cell #(
  parameter int SLOT_W = 4,
  parameter int INDEX  = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mtcd_pkg::cell_ctrl_t            ctrl,
  input  logic signed [mtcd_pkg::KEY_W-1:0] key_x,
  input  logic signed [mtcd_pkg::KEY_W-1:0] key_z,
  input  logic [SLOT_W-1:0]               pos,
  input  logic [SLOT_W-1:0]               prev_slot,
  input  mtcd_pkg::entry_tag_t            prev_tag,
  output logic [SLOT_W-1:0]               cell_slot,
  output mtcd_pkg::entry_tag_t            cell_tag,
  output logic                            match
);
  import mtcd_pkg::*;

  localparam logic [SLOT_W-1:0] IDX = SLOT_W'(INDEX);

  logic [SLOT_W-1:0]       slot_id;
  logic                    valid;
  logic signed [KEY_W-1:0] tag_x;
  logic signed [KEY_W-1:0] tag_z;
  logic                    shift_in;

  // Every position up to the one being moved takes the word from its front neighbour.
  assign shift_in = ctrl.update && (pos >= IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_id <= IDX;
      valid   <= 1'b0;
      match   <= 1'b0;
    end else begin
      if (ctrl.compare) begin
        match <= valid && (tag_x == key_x) && (tag_z == key_z);
      end
      if (shift_in) begin
        slot_id <= prev_slot;
        valid   <= prev_tag.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_in) begin
      tag_x <= prev_tag.x;
      tag_z <= prev_tag.z;
    end
  end

  assign cell_slot = slot_id;
  assign cell_tag  = '{x: tag_x, z: tag_z, valid: valid};

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the recency-ordered tag directory: random and directed lookups.
module testbench;

  localparam int SLOTS = 16;
  localparam int KEY_W = mtcd_pkg::KEY_W;
  localparam int FIELD_W = mtcd_pkg::FIELD_W;
  localparam int POOL_SIZE = 24;
  localparam int RANDOM_WORDS = 1450;

  typedef struct {
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] z;
    int unsigned      idle_pct;
    bit               hold_for_drain;
  } lookup_word_t;

  typedef struct {
    logic               hit;
    logic [FIELD_W-1:0] slot;
    logic [FIELD_W-1:0] pos;
  } dir_result_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [KEY_W-1:0]  key_x;
  logic signed [KEY_W-1:0]  key_z;
  logic                     done;
  logic                     hit;
  logic [FIELD_W-1:0]       slot;
  logic [FIELD_W-1:0]       recency_position;

  // Predicted directory contents.
  logic [FIELD_W-1:0] rec_order [SLOTS];
  logic [KEY_W-1:0]   tag_x [SLOTS];
  logic [KEY_W-1:0]   tag_z [SLOTS];
  bit                 slot_valid [SLOTS];

  lookup_word_t pend_q [$];
  dir_result_t  result_q [$];
  bit           took_word;
  int unsigned  err_count;
  int unsigned  n_words;
  int unsigned  n_hits;
  int unsigned  n_results;
  logic [FIELD_W-1:0] deepest_hit;

  logic [KEY_W-1:0] pool_x [POOL_SIZE];
  logic [KEY_W-1:0] pool_z [POOL_SIZE];

  mru_tag_cache_directory_unit #(.CACHE_SLOTS(SLOTS)) u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .key_x            (key_x),
    .key_z            (key_z),
    .done             (done),
    .hit              (hit),
    .slot             (slot),
    .recency_position (recency_position)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Searches front to back, then moves the found (or least recent) entry to the front.
  function automatic dir_result_t lookup_directory(input logic [KEY_W-1:0] kx,
                                                   input logic [KEY_W-1:0] kz);
    dir_result_t        r;
    bit                 found;
    int                 pos;
    logic [FIELD_W-1:0] s;
    found = 1'b0;
    pos = SLOTS - 1;
    for (int i = 0; i < SLOTS; i++) begin
      s = rec_order[i];
      if (!found && slot_valid[s] && tag_x[s] == kx && tag_z[s] == kz) begin
        found = 1'b1;
        pos = i;
      end
    end
    s = rec_order[pos];
    for (int j = pos; j > 0; j--) begin
      rec_order[j] = rec_order[j-1];
    end
    rec_order[0] = s;
    if (!found) begin
      tag_x[s] = kx;
      tag_z[s] = kz;
      slot_valid[s] = 1'b1;
    end
    r.hit = found;
    r.slot = s;
    r.pos = found ? pos[FIELD_W-1:0] : '0;
    return r;
  endfunction

  task automatic queue_word(input logic [KEY_W-1:0] x, input logic [KEY_W-1:0] z,
                            input int unsigned idle_pct, input bit hold_for_drain);
    lookup_word_t w;
    w.x = x;
    w.z = z;
    w.idle_pct = idle_pct;
    w.hold_for_drain = hold_for_drain;
    pend_q.push_back(w);
  endtask

  task automatic report_error(input string msg);
    if (err_count < 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Driver: a word offered stays on the inputs until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !took_word)) begin
      if (pend_q.size() == 0) begin
        start <= 1'b0;
      end else if (pend_q[0].hold_for_drain && result_q.size() != 0) begin
        start <= 1'b0;
      end else if ($urandom_range(0, 99) < pend_q[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        key_x <= pend_q[0].x;
        key_z <= pend_q[0].z;
      end
    end
  end

  // Monitor: checks each strobed result, and predicts each word as it is taken.
  always @(posedge clk) begin : result_check
    dir_result_t want;
    dir_result_t got;
    if (!rst) begin
      if (done) begin
        n_results++;
        got.hit = hit;
        got.slot = slot;
        got.pos = recency_position;
        if (result_q.size() == 0) begin
          report_error($sformatf("result with nothing expected: hit=%0b slot=%0d pos=%0d",
                                 got.hit, got.slot, got.pos));
        end else begin
          want = result_q.pop_front();
          if (got.hit !== want.hit || got.slot !== want.slot || got.pos !== want.pos) begin
            report_error($sformatf("expected hit=%0b slot=%0d pos=%0d, got hit=%0b slot=%0d pos=%0d",
                                   want.hit, want.slot, want.pos, got.hit, got.slot, got.pos));
          end
        end
      end
      if (start && !busy) begin
        want = lookup_directory(key_x, key_z);
        result_q.push_back(want);
        n_words++;
        if (want.hit) begin
          n_hits++;
          if (want.pos > deepest_hit) begin
            deepest_hit = want.pos;
          end
        end
        pend_q.delete(0);
      end
    end
    took_word <= !rst && start && !busy;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_pct;
    int unsigned live;
    int          p;
    int          r;
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] z;
    rst = 1'b1;
    start = 1'b0;
    key_x = '0;
    key_z = '0;
    took_word = 1'b0;
    err_count = 0;
    n_words = 0;
    n_hits = 0;
    n_results = 0;
    deepest_hit = '0;
    for (int i = 0; i < SLOTS; i++) begin
      rec_order[i] = FIELD_W'(i);
      tag_x[i] = '0;
      tag_z[i] = '0;
      slot_valid[i] = 1'b0;
    end

    // Directed words. The all-zero key must miss on an empty directory, then hit at
    // the front; fifteen fresh keys push it to the back, where it must still hit.
    queue_word(32'h0000_0000, 32'h0000_0000, 38, 1'b0);
    queue_word(32'h0000_0000, 32'h0000_0000, 38, 1'b0);
    queue_word(32'h8000_0000, 32'h7fff_ffff, 38, 1'b0);
    queue_word(32'h7fff_ffff, 32'h8000_0000, 38, 1'b0);
    queue_word(32'hffff_ffff, 32'hffff_ffff, 38, 1'b0);
    queue_word(32'h0000_0000, 32'h0000_0001, 38, 1'b0);
    queue_word(32'h0000_0001, 32'h0000_0000, 38, 1'b0);
    for (int i = 2; i < 12; i++) begin
      queue_word(i * 32'h1111_1111, ~(i * 32'h0101_0101), 38, 1'b0);
    end
    queue_word(32'h0000_0000, 32'h0000_0000, 38, 1'b0);
    // A fresh key now evicts the least recent entry, which then misses in turn.
    queue_word(32'hffff_ffff, 32'h0000_0000, 38, 1'b0);
    queue_word(32'h8000_0000, 32'h7fff_ffff, 38, 1'b0);
    queue_word(32'h8000_0000, 32'h7fff_ffff, 38, 1'b1);

    // Random words: mostly keys from a small working set so hits and evictions both
    // happen, some near misses with one bit changed, and some wholly fresh keys.
    live = 16;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n < RANDOM_WORDS / 3) begin
        phase_pct = 38;
      end else if (n < 2 * RANDOM_WORDS / 3) begin
        phase_pct = 78;
      end else begin
        phase_pct = 0;
      end
      if (n % 300 == 0) begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          pool_x[i] = $urandom;
          pool_z[i] = $urandom;
        end
      end
      if (n % 100 == 0) begin
        case ($urandom_range(0, 4))
          0: live = 4;
          1: live = 12;
          2: live = 16;
          3: live = 17;
          default: live = POOL_SIZE;
        endcase
      end
      p = $urandom_range(0, live - 1);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        x = pool_x[p];
        z = pool_z[p];
      end else if (r < 82) begin
        x = pool_x[p];
        z = pool_z[p];
        if ($urandom_range(0, 1)) begin
          x[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        end else begin
          z[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        end
      end else begin
        x = $urandom;
        z = $urandom;
      end
      queue_word(x, z, phase_pct,
                 n == RANDOM_WORDS / 6 || n == RANDOM_WORDS / 3 || n == 2 * RANDOM_WORDS / 3);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pend_q.size() != 0) begin
      @(posedge clk);
    end
    for (int i = 0; i < 200 && result_q.size() != 0; i++) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    while (result_q.size() != 0) begin
      void'(result_q.pop_front());
      report_error("expected result never arrived");
    end

    $display("Covered %0d lookups: %0d hits (deepest recency position %0d), %0d misses.",
             n_words, n_hits, deepest_hit, n_words - n_hits);
    $display("Results seen: %0d, errors: %0d.", n_results, err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mtcd_pkg.sv
rtl/core/mtcd_cell.sv
rtl/core/mru_tag_cache_directory_unit.sv
verif/testbench.sv
